// ===== src/bom_pkg.sv =====
// shared constants for the box overlap matcher: request modes and field widths
// no dependencies; used by box_overlap_matcher_top and the testbench
package bom_pkg;

  localparam int MODE_W  = 2;
  localparam int LT_W    = 12;
  localparam int RB_W    = 13;
  localparam int INDEX_W = 4;
  localparam int AREA_W  = 25;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // largest coordinate width
  localparam int MAX_COORD_BITS = 16;

endpackage

// ===== src/bom_cell.sv =====
// one cell of the matcher chain: holds one tracked rectangle and runs a query
// through three steps (extents, area product, best compare) in step with its neighbors
// depends on no package
module bom_cell #(
  parameter int COORD_BITS = 12,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  // table write and fill level
  input  logic                      wr_en,
  input  logic [COORD_BITS-1:0]     wr_left,
  input  logic [COORD_BITS-1:0]     wr_top,
  input  logic [COORD_BITS:0]       wr_right,
  input  logic [COORD_BITS:0]       wr_bottom,
  input  logic [CNT_W-1:0]          entry_count,
  // query token from the left neighbor
  input  logic                      go_in,
  input  logic [COORD_BITS-1:0]     q_left_in,
  input  logic [COORD_BITS-1:0]     q_top_in,
  input  logic [COORD_BITS:0]       q_right_in,
  input  logic [COORD_BITS:0]       q_bottom_in,
  input  logic                      ok_in,
  input  logic [COORD_BITS:0]       w_in,
  input  logic [COORD_BITS:0]       h_in,
  input  logic [2*COORD_BITS+1:0]   prod_in,
  input  logic [2*COORD_BITS+1:0]   best_in,
  input  logic [IDX_W-1:0]          best_idx_in,
  // query token to the right neighbor
  output logic                      go_out,
  output logic [COORD_BITS-1:0]     q_left_out,
  output logic [COORD_BITS-1:0]     q_top_out,
  output logic [COORD_BITS:0]       q_right_out,
  output logic [COORD_BITS:0]       q_bottom_out,
  output logic                      ok_out,
  output logic [COORD_BITS:0]       w_out,
  output logic [COORD_BITS:0]       h_out,
  output logic [2*COORD_BITS+1:0]   prod_out,
  output logic [2*COORD_BITS+1:0]   best_out,
  output logic [IDX_W-1:0]          best_idx_out
);

  localparam int PW = 2 * COORD_BITS + 2;
  // the area arriving here belongs to the entry two cells back
  localparam logic [IDX_W-1:0] CMP_IDX = (IDX >= 2) ? IDX_W'(IDX - 2) : '0;

  logic [COORD_BITS-1:0] e_left;
  logic [COORD_BITS-1:0] e_top;
  logic [COORD_BITS:0]   e_right;
  logic [COORD_BITS:0]   e_bottom;

  logic                  entry_vld;
  logic [COORD_BITS-1:0] l_max;
  logic [COORD_BITS-1:0] t_max;
  logic [COORD_BITS:0]   r_min;
  logic [COORD_BITS:0]   b_min;
  logic [COORD_BITS+1:0] w_diff;
  logic [COORD_BITS+1:0] h_diff;

  assign entry_vld = (int'(entry_count) > IDX);

  assign l_max  = (q_left_in > e_left) ? q_left_in : e_left;
  assign t_max  = (q_top_in > e_top) ? q_top_in : e_top;
  assign r_min  = (q_right_in < e_right) ? q_right_in : e_right;
  assign b_min  = (q_bottom_in < e_bottom) ? q_bottom_in : e_bottom;
  assign w_diff = {1'b0, r_min} - {2'b00, l_max};
  assign h_diff = {1'b0, b_min} - {2'b00, t_max};

  always_ff @(posedge clk) begin
    if (wr_en && (int'(entry_count) == IDX)) begin
      e_left   <= wr_left;
      e_top    <= wr_top;
      e_right  <= wr_right;
      e_bottom <= wr_bottom;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      go_out <= 1'b0;
    end else begin
      go_out <= go_in;
    end
  end

  always_ff @(posedge clk) begin
    q_left_out   <= q_left_in;
    q_top_out    <= q_top_in;
    q_right_out  <= q_right_in;
    q_bottom_out <= q_bottom_in;
    // extents of this cell's entry; a negative extent means no overlap
    ok_out       <= entry_vld && !w_diff[COORD_BITS+1] && !h_diff[COORD_BITS+1];
    w_out        <= w_diff[COORD_BITS:0];
    h_out        <= h_diff[COORD_BITS:0];
    // area of the previous cell's entry
    prod_out     <= ok_in ? (PW'(w_in) * PW'(h_in)) : '0;
    // strict compare keeps the lowest index on ties
    if (prod_in > best_in) begin
      best_out     <= prod_in;
      best_idx_out <= CMP_IDX;
    end else begin
      best_out     <= best_in;
      best_idx_out <= best_idx_in;
    end
  end

endmodule

// ===== src/box_overlap_matcher_top.sv =====
// box overlap matcher: table of tracked rectangles with best-overlap lookup
// built from a chain of bom_cell instances; depends on bom_pkg
//
// usage:
//   a request is taken at a rising edge with start high and busy low; mode
//   selects append (store the rectangle), clear (empty the table) or query.
//   appends and clears finish at the edge that takes them, so while no query
//   is in flight one can be taken every cycle; a full table drops appends.
//   a query walks a row of MAX_TRACKED + 2 cells, one cell per cycle: each
//   cell holds at most one entry, works out its overlap extents, multiplies the
//   previous entry's extents and keeps the running best of the entry before.
//   the result (matched, match_index, best_area) shows for one cycle with
//   done high once the query has left the last cell, and is taken at the
//   edge that ends that cycle. busy is high from the query until that done
//   cycle, and a new request can be taken in the done cycle itself, so a
//   new query is taken only after the last one has shown its result.
//   the receiver cannot stall; done is a one-cycle strobe.
//   reset empties the table and drops any query in flight; entries hold
//   whatever was last written and are only read below the fill count.
//   best_area saturates at its all-ones value; match_index is the low bits
//   of the winning table index.
module box_overlap_matcher_top #(
  parameter int MAX_TRACKED = 16,
  parameter int COORD_BITS  = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bom_pkg::MODE_W-1:0]    mode,
  input  logic [bom_pkg::LT_W-1:0]      left_x,
  input  logic [bom_pkg::LT_W-1:0]      top_y,
  input  logic [bom_pkg::RB_W-1:0]      right_x,
  input  logic [bom_pkg::RB_W-1:0]      bottom_y,
  output logic                          done,
  output logic                          matched,
  output logic [bom_pkg::INDEX_W-1:0]   match_index,
  output logic [bom_pkg::AREA_W-1:0]    best_area
);

  localparam int NC    = MAX_TRACKED + 2;
  localparam int IDX_W = (MAX_TRACKED > 1) ? $clog2(MAX_TRACKED) : 1;
  localparam int CNT_W = $clog2(MAX_TRACKED + 1);
  localparam int PW    = 2 * COORD_BITS + 2;
  localparam int CW    = (PW > bom_pkg::AREA_W) ? PW : bom_pkg::AREA_W;

  logic                  busy_reg;
  logic [CNT_W-1:0]      entry_count;
  logic                  accept;
  logic                  q_accept;
  logic                  app_accept;
  logic                  clr_accept;

  logic [COORD_BITS-1:0] in_left;
  logic [COORD_BITS-1:0] in_top;
  logic [COORD_BITS:0]   in_right;
  logic [COORD_BITS:0]   in_bottom;

  logic                  go_c     [0:NC];
  logic [COORD_BITS-1:0] ql_c     [0:NC];
  logic [COORD_BITS-1:0] qt_c     [0:NC];
  logic [COORD_BITS:0]   qr_c     [0:NC];
  logic [COORD_BITS:0]   qb_c     [0:NC];
  logic                  ok_c     [0:NC];
  logic [COORD_BITS:0]   w_c      [0:NC];
  logic [COORD_BITS:0]   h_c      [0:NC];
  logic [PW-1:0]         prod_c   [0:NC];
  logic [PW-1:0]         best_c   [0:NC];
  logic [IDX_W-1:0]      bidx_c   [0:NC];

  logic [CW-1:0]         best_wide;

  assign in_left   = COORD_BITS'(left_x);
  assign in_top    = COORD_BITS'(top_y);
  assign in_right  = (COORD_BITS + 1)'(right_x);
  assign in_bottom = (COORD_BITS + 1)'(bottom_y);

  assign busy   = busy_reg && !done;
  assign accept = start && !busy;

  always_comb begin
    q_accept   = 1'b0;
    app_accept = 1'b0;
    clr_accept = 1'b0;
    case (mode)
      bom_pkg::MODE_APPEND: app_accept = accept;
      bom_pkg::MODE_QUERY:  q_accept   = accept;
      bom_pkg::MODE_CLEAR:  clr_accept = accept;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_reg    <= 1'b0;
      entry_count <= '0;
    end else begin
      if (q_accept) begin
        busy_reg <= 1'b1;
      end else if (done) begin
        busy_reg <= 1'b0;
      end
      if (clr_accept) begin
        entry_count <= '0;
      end else if (app_accept && (entry_count != CNT_W'(MAX_TRACKED))) begin
        entry_count <= entry_count + 1'b1;
      end
    end
  end

  // head of the chain: fresh query token with nothing found yet
  assign go_c[0]   = q_accept;
  assign ql_c[0]   = in_left;
  assign qt_c[0]   = in_top;
  assign qr_c[0]   = in_right;
  assign qb_c[0]   = in_bottom;
  assign ok_c[0]   = 1'b0;
  assign w_c[0]    = '0;
  assign h_c[0]    = '0;
  assign prod_c[0] = '0;
  assign best_c[0] = '0;
  assign bidx_c[0] = '0;

  // two trailing cells hold no entry and drain the product and compare steps
  for (genvar k = 0; k < NC; k++) begin : g_cell
    bom_cell #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .IDX        (k)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .wr_en        (app_accept),
      .wr_left      (in_left),
      .wr_top       (in_top),
      .wr_right     (in_right),
      .wr_bottom    (in_bottom),
      .entry_count  (entry_count),
      .go_in        (go_c[k]),
      .q_left_in    (ql_c[k]),
      .q_top_in     (qt_c[k]),
      .q_right_in   (qr_c[k]),
      .q_bottom_in  (qb_c[k]),
      .ok_in        (ok_c[k]),
      .w_in         (w_c[k]),
      .h_in         (h_c[k]),
      .prod_in      (prod_c[k]),
      .best_in      (best_c[k]),
      .best_idx_in  (bidx_c[k]),
      .go_out       (go_c[k+1]),
      .q_left_out   (ql_c[k+1]),
      .q_top_out    (qt_c[k+1]),
      .q_right_out  (qr_c[k+1]),
      .q_bottom_out (qb_c[k+1]),
      .ok_out       (ok_c[k+1]),
      .w_out        (w_c[k+1]),
      .h_out        (h_c[k+1]),
      .prod_out     (prod_c[k+1]),
      .best_out     (best_c[k+1]),
      .best_idx_out (bidx_c[k+1])
    );
  end

  assign best_wide   = CW'(best_c[NC]);
  assign done        = go_c[NC];
  assign matched     = (best_c[NC] != '0);
  assign match_index = bom_pkg::INDEX_W'(bidx_c[NC]);
  assign best_area   = (best_wide > CW'(bom_pkg::AREA_MAX)) ? bom_pkg::AREA_MAX
                                                            : best_wide[bom_pkg::AREA_W-1:0];

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy_reg))
    else $error("result strobe without a query in flight");

  a_query_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == bom_pkg::MODE_QUERY) |=> busy_reg)
    else $error("query taken but busy not raised");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(entry_count) <= MAX_TRACKED)
    else $error("fill count beyond table depth");

  a_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !matched) |-> (best_area == '0 && match_index == '0))
    else $error("unmatched result carries nonzero index or area");

  a_append_counts: assert property (@(posedge clk) disable iff (rst)
    (app_accept && (entry_count != CNT_W'(MAX_TRACKED)))
      |=> (entry_count == $past(entry_count) + 1'b1))
    else $error("append did not advance fill count");

endmodule

// ===== sim/tb_box_overlap_matcher_top.sv =====
// testbench for box_overlap_matcher_top: directed table then random request streams
// checks every query result against a typed value or an in-bench overlap predictor; depends on bom_pkg
module tb_box_overlap_matcher_top;

  localparam int TRACK_DEPTH = 16;
  localparam int BUSY_CYCLES = TRACK_DEPTH + 2;
  localparam int TOTAL_REQUESTS = 1520;
  localparam int QUIET_TAIL = 250;
  localparam int LIMIT_CYCLES = 400000;

  typedef logic [bom_pkg::MODE_W-1:0] mode_t;
  typedef logic [bom_pkg::LT_W-1:0] lt_t;
  typedef logic [bom_pkg::RB_W-1:0] rb_t;
  typedef logic [bom_pkg::INDEX_W-1:0] slot_t;
  typedef logic [bom_pkg::AREA_W-1:0] area_t;
  localparam mode_t MODE_UNUSED = 2'd3;

  typedef struct packed {
    lt_t left;
    lt_t top;
    rb_t right;
    rb_t bottom;
  } rect_t;

  typedef struct packed {
    logic  matched;
    slot_t slot;
    area_t area;
  } match_t;

  localparam match_t NO_MATCH = '0;

  typedef struct {
    mode_t  m;
    rect_t  r;
    int     reps;
    bit     has_typed;
    match_t typed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  mode_t mode = bom_pkg::MODE_APPEND;
  lt_t left_x = '0;
  lt_t top_y = '0;
  rb_t right_x = '0;
  rb_t bottom_y = '0;
  logic done;
  logic matched;
  slot_t match_index;
  area_t best_area;

  rect_t tracked_tbl[TRACK_DEPTH];
  int tracked_count = 0;
  match_t pending_matches[$];
  int mismatch_count = 0;
  int request_count = 0;
  int cycle_count = 0;
  bit idle_allowed = 1'b1;
  int scene_x = 0;
  int scene_y = 0;
  row_t dir_rows[$];

  box_overlap_matcher_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .left_x(left_x),
    .top_y(top_y),
    .right_x(right_x),
    .bottom_y(bottom_y),
    .done(done),
    .matched(matched),
    .match_index(match_index),
    .best_area(best_area)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // largest strictly positive overlap over the filled part of the table
  function automatic match_t best_overlap(rect_t q);
    match_t res;
    longint best;
    longint a;
    int w;
    int h;
    res = NO_MATCH;
    best = 0;
    for (int j = 0; j < tracked_count; j++) begin
      w = ((q.right < tracked_tbl[j].right) ? int'(q.right) : int'(tracked_tbl[j].right))
        - ((q.left > tracked_tbl[j].left) ? int'(q.left) : int'(tracked_tbl[j].left));
      h = ((q.bottom < tracked_tbl[j].bottom) ? int'(q.bottom) : int'(tracked_tbl[j].bottom))
        - ((q.top > tracked_tbl[j].top) ? int'(q.top) : int'(tracked_tbl[j].top));
      a = (w < 0 || h < 0) ? 0 : longint'(w) * longint'(h);
      if (a > best) begin
        best = a;
        res.matched = 1'b1;
        res.slot = slot_t'(j);
      end
    end
    res.area = (best > longint'(bom_pkg::AREA_MAX)) ? bom_pkg::AREA_MAX : area_t'(best);
    return res;
  endfunction

  function automatic rect_t any_rect();
    rect_t r;
    r.left = lt_t'($urandom_range(0, 4095));
    r.top = lt_t'($urandom_range(0, 4095));
    r.right = rb_t'($urandom_range(0, 8191));
    r.bottom = rb_t'($urandom_range(0, 8191));
    return r;
  endfunction

  // mostly small boxes around a shared spot so that overlaps and ties are common
  function automatic rect_t pick_rect();
    rect_t r;
    int sel;
    int l;
    int t;
    int w;
    int h;
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      l = scene_x + $urandom_range(0, 48);
      t = scene_y + $urandom_range(0, 48);
      w = int'($urandom_range(0, 56)) - 6;
      h = int'($urandom_range(0, 56)) - 6;
      r.left = lt_t'(l);
      r.top = lt_t'(t);
      r.right = (l + w < 0) ? '0 : rb_t'(l + w);
      r.bottom = (t + h < 0) ? '0 : rb_t'(t + h);
    end else if (sel < 92) begin
      r = any_rect();
    end else begin
      // huge boxes whose overlap runs past the area range
      r.left = lt_t'($urandom_range(0, 200));
      r.top = lt_t'($urandom_range(0, 200));
      r.right = rb_t'(8191 - $urandom_range(0, 200));
      r.bottom = rb_t'(8191 - $urandom_range(0, 200));
    end
    return r;
  endfunction

  task automatic add_row(input mode_t m, input rect_t r, input int reps, input bit has_typed,
                         input match_t typed);
    row_t row;
    row.m = m;
    row.r = r;
    row.reps = reps;
    row.has_typed = has_typed;
    row.typed = typed;
    dir_rows = {dir_rows, row};
  endtask

  task automatic send_request(input mode_t m, input rect_t r, input bit has_typed,
                              input match_t typed);
    match_t predicted;
    start <= 1'b1;
    mode <= m;
    left_x <= r.left;
    top_y <= r.top;
    right_x <= r.right;
    bottom_y <= r.bottom;
    do @(posedge clk); while (busy);
    case (m)
      bom_pkg::MODE_APPEND: begin
        if (tracked_count < TRACK_DEPTH) begin
          tracked_tbl[tracked_count] = r;
          tracked_count++;
        end
      end
      bom_pkg::MODE_CLEAR: begin
        tracked_count = 0;
      end
      bom_pkg::MODE_QUERY: begin
        predicted = has_typed ? typed : best_overlap(r);
        pending_matches = {pending_matches, predicted};
      end
      default: ;
    endcase
    if (m != MODE_UNUSED) request_count++;
    if (idle_allowed && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string field, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    match_t want;
    if (!rst && done) begin
      if (pending_matches.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with no query pending", $time);
      end else begin
        want = pending_matches.pop_front();
        if (matched !== want.matched) report_mismatch("matched", want.matched, matched);
        if (match_index !== want.slot) report_mismatch("match_index", want.slot, match_index);
        if (best_area !== want.area) report_mismatch("best_area", want.area, best_area);
      end
    end
  end

  initial begin
    int n;
    int q;
    // empty table after reset
    add_row(bom_pkg::MODE_QUERY, {12'd0, 12'd0, 13'd4096, 13'd4096}, 1, 1'b1, NO_MATCH);
    add_row(MODE_UNUSED, {12'd5, 12'd5, 13'd50, 13'd50}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_APPEND, {12'd0, 12'd0, 13'd4096, 13'd4096}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_QUERY, {12'd0, 12'd0, 13'd4096, 13'd4096}, 1, 1'b1,
            {1'b1, 4'd0, 25'd16777216});
    add_row(bom_pkg::MODE_APPEND, {12'd4095, 12'd4095, 13'd4096, 13'd4096}, 1, 1'b0, NO_MATCH);
    // equal areas, lowest slot wins
    add_row(bom_pkg::MODE_QUERY, {12'd4095, 12'd4095, 13'd4096, 13'd4096}, 1, 1'b1,
            {1'b1, 4'd0, 25'd1});
    add_row(bom_pkg::MODE_CLEAR, {12'd0, 12'd0, 13'd0, 13'd0}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_QUERY, {12'd0, 12'd0, 13'd4096, 13'd4096}, 1, 1'b1, NO_MATCH);
    // inverted box, then a zero-width one
    add_row(bom_pkg::MODE_APPEND, {12'd100, 12'd100, 13'd50, 13'd200}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_QUERY, {12'd0, 12'd0, 13'd4096, 13'd4096}, 1, 1'b1, NO_MATCH);
    add_row(bom_pkg::MODE_APPEND, {12'd200, 12'd200, 13'd200, 13'd300}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_QUERY, {12'd0, 12'd0, 13'd4096, 13'd4096}, 1, 1'b1, NO_MATCH);
    // oversized overlaps compare exactly and saturate on output
    add_row(bom_pkg::MODE_APPEND, {12'd0, 12'd0, 13'd8191, 13'd8191}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_APPEND, {12'd0, 12'd0, 13'd8191, 13'd8000}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_QUERY, {12'd0, 12'd0, 13'd8191, 13'd8191}, 1, 1'b1,
            {1'b1, 4'd2, bom_pkg::AREA_MAX});
    add_row(bom_pkg::MODE_QUERY, {12'd0, 12'd0, 13'd8191, 13'd8000}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_QUERY, {12'd4095, 12'd4095, 13'd8191, 13'd8191}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_QUERY, {12'd4095, 12'd4095, 13'd0, 13'd0}, 1, 1'b1, NO_MATCH);
    // fill the table, the extra append must be dropped
    add_row(bom_pkg::MODE_CLEAR, {12'd4095, 12'd4095, 13'd8191, 13'd8191}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_APPEND, {12'd0, 12'd0, 13'd10, 13'd10}, TRACK_DEPTH, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_APPEND, {12'd0, 12'd0, 13'd4096, 13'd4096}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_QUERY, {12'd0, 12'd0, 13'd4096, 13'd4096}, 1, 1'b1,
            {1'b1, 4'd0, 25'd100});
    add_row(MODE_UNUSED, {12'd4095, 12'd4095, 13'd8191, 13'd8191}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_QUERY, {12'd5, 12'd5, 13'd8191, 13'd8191}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_CLEAR, {12'd4095, 12'd4095, 13'd8191, 13'd8191}, 1, 1'b0, NO_MATCH);
    add_row(bom_pkg::MODE_QUERY, {12'd4095, 12'd4095, 13'd8191, 13'd8191}, 1, 1'b1, NO_MATCH);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      idle_allowed = ($urandom_range(0, 1) == 0);
      repeat (dir_rows[i].reps)
        send_request(dir_rows[i].m, dir_rows[i].r, dir_rows[i].has_typed, dir_rows[i].typed);
    end

    // random part: mostly clear, fill, query sequences with some loose requests
    while (request_count < TOTAL_REQUESTS) begin
      idle_allowed = (request_count < TOTAL_REQUESTS - QUIET_TAIL) &&
                     ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 99) < 85) begin
        scene_x = $urandom_range(0, 4040);
        scene_y = $urandom_range(0, 4040);
        if ($urandom_range(0, 9) < 7)
          send_request(bom_pkg::MODE_CLEAR, any_rect(), 1'b0, NO_MATCH);
        n = $urandom_range(1, TRACK_DEPTH + 1);
        repeat (n) send_request(bom_pkg::MODE_APPEND, pick_rect(), 1'b0, NO_MATCH);
        q = $urandom_range(1, 5);
        repeat (q) send_request(bom_pkg::MODE_QUERY, pick_rect(), 1'b0, NO_MATCH);
      end else begin
        send_request(mode_t'($urandom_range(0, 3)), any_rect(), 1'b0, NO_MATCH);
      end
    end

    start <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (BUSY_CYCLES + 4) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
